FILE: hdl/assert_macros.svh
// Assertion macros used by the RTL of the COBS packet deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define CPD_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Same-cycle implication.
`define CPD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define CPD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CPD_ASSERT(lbl, cond, msg)
`define CPD_ASSERT_IMP(lbl, ante, cons, msg)
`define CPD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hdl/cpd_pkg.sv
// Types and codes of the COBS packet deframer.
package cpd_pkg;

	// Frame phase
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	// Result kinds
	localparam logic [1:0] KIND_ID      = 2'd0;
	localparam logic [1:0] KIND_LEN     = 2'd1;
	localparam logic [1:0] KIND_PAYLOAD = 2'd2;
	localparam logic [1:0] KIND_STATUS  = 2'd3;

	// Frame status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_CHECK  = 2'd1;
	localparam logic [1:0] ST_BADLEN = 2'd2;

	// Saturation point of the decoded byte count
	localparam logic [8:0] COUNT_MAX = 9'd511;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_start;
	} frame_in_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic [1:0] status;
		logic       last;
	} frame_out_t;

endpackage

FILE: hdl/cobs_packet_deframer.sv
// COBS packet deframer: streaming decode, XOR check, status per frame.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  in      | in_valid / in_ready    | in_data  (frame_byte, frame_start)
//  out     | out_valid / out_ready  | out_data (kind, value, status, last)
//  cfg     | cfg_valid / cfg_ready  | cfg_data (max_payload_bytes)
//
// One byte per cycle sustained while the queue has room. A byte is captured
// in the input register, is decoded there against the frame counters and drops
// its results (zero, one or two) into a four-entry output queue.
// The input stage advances while the queue holds at least two free slots.
// Reset clears frame state to idle and sets max_payload_bytes to 255.
// Output stalls back up the queue, then input; cfg_ready is always high.
`include "assert_macros.svh"

module cobs_packet_deframer #(
	parameter int unsigned QDEPTH_LOG2 = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cpd_pkg::frame_in_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output cpd_pkg::frame_out_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [7:0]           cfg_data
);

	localparam int unsigned QDEPTH = 1 << QDEPTH_LOG2;
	localparam logic [QDEPTH_LOG2:0] CNT_ROOM = (QDEPTH_LOG2 + 1)'(QDEPTH - 2);
	localparam logic [QDEPTH_LOG2:0] CNT_FULL = (QDEPTH_LOG2 + 1)'(QDEPTH);

	// Input register
	logic               valid_s1;
	cpd_pkg::frame_in_t item_s1;
	logic               adv;

	// Config register
	logic [7:0] max_pay_q;

	// Frame state
	cpd_pkg::phase_t phase_q, phase_d;
	logic [7:0] enc_left_q, enc_left_d;
	logic [7:0] blk_left_q, blk_left_d;
	logic       first_seen_q, first_seen_d;
	logic [8:0] dcount_q, dcount_d;
	logic [7:0] plen_q, plen_d;
	logic [7:0] xor_q, xor_d;
	logic [7:0] rcheck_q, rcheck_d;
	logic       chk_cap_q, chk_cap_d;

	// Decode outputs
	logic               take;
	logic [7:0]         take_byte;
	logic               emit_dec;
	cpd_pkg::frame_out_t dec_res;
	logic               finish;
	logic               frame_bad;
	cpd_pkg::frame_out_t st_res;

	// Result queue
	cpd_pkg::frame_out_t     queue_q [QDEPTH];
	logic [QDEPTH_LOG2-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QDEPTH_LOG2:0]    cnt_q;
	logic [1:0]              n_push;
	cpd_pkg::frame_out_t     push0, push1;
	logic                    pop;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (cnt_q <= CNT_ROOM);
	assign in_ready  = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pay_q <= 8'd255;
		end else if (cfg_valid && cfg_ready) begin
			max_pay_q <= cfg_data;
		end
	end

	// Frame sequencing: phase, counters, block tracking
	always_comb begin
		phase_d      = phase_q;
		enc_left_d   = enc_left_q;
		blk_left_d   = blk_left_q;
		first_seen_d = first_seen_q;
		take         = 1'b0;
		take_byte    = 8'd0;
		finish       = 1'b0;
		if (adv) begin
			if (item_s1.frame_start) begin
				phase_d      = cpd_pkg::PH_LEN;
				enc_left_d   = 8'd0;
				blk_left_d   = 8'd0;
				first_seen_d = 1'b0;
			end else begin
				unique case (phase_q)
					cpd_pkg::PH_LEN: begin
						enc_left_d = item_s1.frame_byte;
						phase_d    = cpd_pkg::PH_BODY;
						finish     = (item_s1.frame_byte == 8'd0);
					end
					cpd_pkg::PH_BODY: begin
						if (enc_left_q == 8'd0) begin
							phase_d = cpd_pkg::PH_IDLE;
						end else begin
							if (blk_left_q == 8'd0) begin
								// code byte: restores a zero unless it opens the frame
								take         = first_seen_q;
								first_seen_d = 1'b1;
								blk_left_d   = (item_s1.frame_byte == 8'd0) ? 8'd0
								               : item_s1.frame_byte - 8'd1;
							end else begin
								take       = 1'b1;
								take_byte  = item_s1.frame_byte;
								blk_left_d = blk_left_q - 8'd1;
							end
							enc_left_d = enc_left_q - 8'd1;
							finish     = (enc_left_q == 8'd1);
						end
					end
					default: begin
						phase_d = cpd_pkg::PH_IDLE;
					end
				endcase
			end
			if (finish) begin
				phase_d = cpd_pkg::PH_IDLE;
			end
		end
	end

	// Decoded byte placement: id, length, payload, checksum
	always_comb begin
		logic [8:0] chk_pos;
		chk_pos   = {1'b0, plen_q} + 9'd2;
		dcount_d  = dcount_q;
		plen_d    = plen_q;
		xor_d     = xor_q;
		rcheck_d  = rcheck_q;
		chk_cap_d = chk_cap_q;
		emit_dec  = 1'b0;
		dec_res   = '0;
		if (adv && item_s1.frame_start) begin
			dcount_d  = 9'd0;
			plen_d    = 8'd0;
			xor_d     = 8'd0;
			rcheck_d  = 8'd0;
			chk_cap_d = 1'b0;
		end else if (take) begin
			dec_res.value = take_byte;
			if (dcount_q == 9'd0) begin
				emit_dec     = 1'b1;
				dec_res.kind = cpd_pkg::KIND_ID;
				xor_d        = xor_q ^ take_byte;
			end else if (dcount_q == 9'd1) begin
				emit_dec     = 1'b1;
				dec_res.kind = cpd_pkg::KIND_LEN;
				plen_d       = take_byte;
				xor_d        = xor_q ^ take_byte;
			end else if (dcount_q < chk_pos) begin
				emit_dec     = 1'b1;
				dec_res.kind = cpd_pkg::KIND_PAYLOAD;
				xor_d        = xor_q ^ take_byte;
			end else if (dcount_q == chk_pos) begin
				rcheck_d  = take_byte;
				chk_cap_d = 1'b1;
			end
			if (dcount_q != cpd_pkg::COUNT_MAX) begin
				dcount_d = dcount_q + 9'd1;
			end
		end
	end

	// End-of-frame status from the updated frame state
	always_comb begin
		frame_bad = (blk_left_d != 8'd0) || !chk_cap_d ||
		            ({1'b0, dcount_d} > ({2'b00, max_pay_q} + 10'd3));
		st_res      = '0;
		st_res.kind = cpd_pkg::KIND_STATUS;
		st_res.last = 1'b1;
		if (frame_bad) begin
			st_res.status = cpd_pkg::ST_BADLEN;
		end else if (xor_d != rcheck_d) begin
			st_res.status = cpd_pkg::ST_CHECK;
		end else begin
			st_res.status = cpd_pkg::ST_OK;
		end
	end

	// Frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= cpd_pkg::PH_IDLE;
			enc_left_q   <= 8'd0;
			blk_left_q   <= 8'd0;
			first_seen_q <= 1'b0;
			dcount_q     <= 9'd0;
			plen_q       <= 8'd0;
			xor_q        <= 8'd0;
			rcheck_q     <= 8'd0;
			chk_cap_q    <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			enc_left_q   <= enc_left_d;
			blk_left_q   <= blk_left_d;
			first_seen_q <= first_seen_d;
			dcount_q     <= dcount_d;
			plen_q       <= plen_d;
			xor_q        <= xor_d;
			rcheck_q     <= rcheck_d;
			chk_cap_q    <= chk_cap_d;
		end
	end

	// Pack the results of this byte into queue order
	always_comb begin
		push0  = dec_res;
		push1  = st_res;
		n_push = 2'd0;
		if (emit_dec && finish) begin
			n_push = 2'd2;
		end else if (emit_dec) begin
			n_push = 2'd1;
		end else if (finish) begin
			push0  = st_res;
			n_push = 2'd1;
		end
	end

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_data  = queue_q[rd_ptr_q];

	// Result queue storage
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			queue_q[wr_ptr_q] <= push0;
		end
		if (n_push == 2'd2) begin
			queue_q[wr_ptr_q + QDEPTH_LOG2'(1)] <= push1;
		end
	end

	// Result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QDEPTH_LOG2'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QDEPTH_LOG2'(1);
			end
			cnt_q <= cnt_q + (QDEPTH_LOG2 + 1)'(n_push) - (QDEPTH_LOG2 + 1)'(pop);
		end
	end

	// Checks
	`CPD_ASSERT(a_queue_bound, cnt_q <= CNT_FULL, "result queue overflow")
	`CPD_ASSERT_IMP(a_push_room, n_push != 2'd0, cnt_q <= CNT_ROOM, "push without room")
	`CPD_ASSERT_IMP(a_stall_held, !in_ready, valid_s1, "input stalled with empty stage")
	`CPD_ASSERT_NXT(a_push_shows, n_push != 2'd0, out_valid, "pushed result not visible")
	`CPD_ASSERT_IMP(a_last_status, out_valid,
		(out_data.last == (out_data.kind == cpd_pkg::KIND_STATUS)),
		"last flag does not match status kind")

endmodule
